>>> hdl/dary_min_heap_decrease_key_unit_defines.svh
// ----------------------------------------------------------------------------
// dary_min_heap_decrease_key_unit_defines.svh
// Assertion macros for the d-ary min-heap unit. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DARY_MIN_HEAP_DECREASE_KEY_UNIT_DEFINES_SVH
`define DARY_MIN_HEAP_DECREASE_KEY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property while out of reset
`define DMH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dmh assertion failed");
// Check a property at every clock edge, reset included
`define DMH_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("dmh assertion failed");
`else
`define DMH_ASSERT(lbl, clk, rst_n, prop)
`define DMH_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> hdl/dmh_pkg.sv
// ----------------------------------------------------------------------------
// dmh_pkg
// Shared types, widths and codes of the d-ary min-heap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dmh_pkg;

  localparam int CAPACITY = 1024;
  localparam int NUM_VTX  = 1024;
  localparam int KW       = 30;                  // key width
  localparam int VW       = 10;                  // vertex width
  localparam int PW       = $clog2(CAPACITY);    // heap position width
  localparam int CW       = PW + 1;              // occupancy width
  localparam int AW       = CW + 1;              // address sum width
  localparam int DW       = 5;                   // arity width
  localparam int CXW      = PW + DW + 1;         // first-child position width
  localparam int RW       = 5;                   // local index in a sibling group
  localparam int ARITY_MIN = 2;
  localparam int ARITY_MAX = 16;
  localparam int ARITY_RST = 2;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DECREASE = 2'd1,
    CMD_EXTRACT  = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_LARGER = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOOKUP, S_POS, S_CHECK,
    S_UP, S_DIV, S_GRP, S_GRP_CMP, S_PAR_RD, S_PAR_CMP,
    S_EX0, S_EX1, S_EX2,
    S_DN, S_DN_L, S_DN_R, S_DN_MV, S_CH, S_CH_CMP,
    S_WRITE, S_DONE
  } state_t;

  typedef struct packed {
    logic [KW-1:0] key;
    logic [VW-1:0] vtx;
  } heap_ent_t;

  typedef struct packed {
    logic            we;
    logic [PW-1:0]   waddr;
    heap_ent_t       wdata;
    logic [PW-1:0]   raddr;
  } heap_port_t;

  typedef struct packed {
    logic            we;
    logic [VW-1:0]   waddr;
    logic [PW-1:0]   wdata;
    logic [VW-1:0]   raddr;
  } pos_port_t;

  typedef struct packed {
    logic            start;
    logic [PW-1:0]   dividend;
    logic [DW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [PW-1:0]   quot;
    logic [DW-1:0]   rem;
  } div_rsp_t;

  // Clamp the arity register into the supported range
  function automatic logic [DW-1:0] eff_arity(input logic [DW-1:0] a);
    logic [DW-1:0] res;
    res = a;
    if (a < DW'(ARITY_MIN)) res = DW'(ARITY_MIN);
    if (a > DW'(ARITY_MAX)) res = DW'(ARITY_MAX);
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/dmh_ram.sv
// ----------------------------------------------------------------------------
// dmh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/dmh_div.sv
// ----------------------------------------------------------------------------
// dmh_div
// Restoring divider, one quotient bit per cycle: position by arity.
// ----------------------------------------------------------------------------
`default_nettype none

module dmh_div
  import dmh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int ITW = $clog2(PW);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [ITW-1:0] iter_r, iter_nxt;
  logic [PW-1:0]  quo_r, quo_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  dvs_r, dvs_nxt;
  logic [DW-1:0]  rem_sh;
  logic           ge;

  // One restoring step
  assign rem_sh = {rem_r[DW-2:0], quo_r[PW-1]};
  assign ge     = rem_sh >= dvs_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[PW-2:0], ge};
      rem_nxt  = ge ? (rem_sh - dvs_r) : rem_sh;
      iter_nxt = iter_r + ITW'(1);
      if (iter_r == ITW'(PW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    iter_r <= iter_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

>>> hdl/dmh_ctrl.sv
// ----------------------------------------------------------------------------
// dmh_ctrl
// Command sequencer: lookup, insert, decrease and extract with hole-based
// sifting over the heap and position memories.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dary_min_heap_decrease_key_unit_defines.svh"

module dmh_ctrl
  import dmh_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      in_cmd,
  input  wire logic [VW-1:0]   in_vertex,
  input  wire logic [KW-1:0]   in_new_key,
  output logic                 out_valid,
  output logic      [VW-1:0]   out_vertex,
  output logic      [KW-1:0]   out_key,
  output logic      [1:0]      out_status,
  output logic      [CW-1:0]   out_occupancy,
  input  wire logic [DW-1:0]   arity,
  output heap_port_t           heap_port,
  input  wire heap_ent_t       heap_rd,
  output pos_port_t            pos_port,
  input  wire logic [PW-1:0]   pos_rd,
  output div_req_t             div_req,
  input  wire div_rsp_t        div_rsp
);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [VW-1:0]  v_r, v_nxt;
  logic [KW-1:0]  key_r, key_nxt;
  heap_ent_t      car_r, car_nxt;        // entry being sifted
  heap_ent_t      sm_r, sm_nxt;          // smallest sibling candidate
  logic           smv_r, smv_nxt;
  logic [RW-1:0]  sr_r, sr_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [RW-1:0]  r_r, r_nxt;
  logic [PW-1:0]  base_r, base_nxt;
  logic [PW-1:0]  f_r, f_nxt;
  logic [PW-1:0]  c_r, c_nxt;
  logic [VW-1:0]  ov_r, ov_nxt;
  logic [KW-1:0]  ok_r, ok_nxt;
  status_t        st_r, st_nxt;
  logic           oval_r;

  logic [DW-1:0]  d;
  logic           full, pres, p_in, up_swap, left_lt, right_lt;
  logic [PW-1:0]  grp_q;
  logic [RW:0]    l_idx, r_idx, d6;
  logic [AW-1:0]  l_addr, r_addr;
  logic           l_ok, r_ok;
  logic [CXW-1:0] c_full;
  logic           c_ok;

  // Shared conditions
  assign d        = eff_arity(arity);
  assign full     = cnt_r >= CW'(CAPACITY);
  assign pres     = heap_rd.vtx == v_r;
  assign p_in     = CW'(pos_rd) < cnt_r;
  assign grp_q    = base_r + PW'(r_r >> 1);
  assign up_swap  = heap_rd.key > car_r.key;
  assign d6       = (RW+1)'(d);
  assign l_idx    = {r_r, 1'b0};
  assign r_idx    = l_idx + (RW+1)'(1);
  assign l_addr   = AW'(base_r) + AW'(l_idx);
  assign r_addr   = l_addr + AW'(1);
  assign l_ok     = (l_idx <= d6) && (l_addr < AW'(cnt_r));
  assign r_ok     = (r_idx <= d6) && (r_addr < AW'(cnt_r));
  assign left_lt  = heap_rd.key < car_r.key;
  assign right_lt = heap_rd.key < (smv_r ? sm_r.key : car_r.key);
  assign c_full   = CXW'(pos_r) * CXW'(d) + CXW'(1);
  assign c_ok     = c_full < CXW'(cnt_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_EXTRACT) begin
            state_nxt = (cnt_r == '0) ? S_DONE : S_EX0;
          end else if (in_cmd == CMD_NOP) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LOOKUP;
          end
        end
      end
      S_LOOKUP:  state_nxt = S_POS;
      S_POS:     state_nxt = p_in ? S_CHECK : (full ? S_DONE : S_UP);
      S_CHECK: begin
        if (pres) begin
          state_nxt = (key_r > heap_rd.key) ? S_DONE : S_UP;
        end else begin
          state_nxt = full ? S_DONE : S_UP;
        end
      end
      S_UP:      state_nxt = (pos_r == '0) ? S_WRITE : S_DIV;
      S_DIV:     state_nxt = div_rsp.done ? S_GRP : S_DIV;
      S_GRP:     state_nxt = (r_r > RW'(1)) ? S_GRP_CMP : S_PAR_CMP;
      S_GRP_CMP: state_nxt = up_swap ? S_GRP : S_PAR_RD;
      S_PAR_RD:  state_nxt = S_PAR_CMP;
      S_PAR_CMP: state_nxt = up_swap ? S_UP : S_WRITE;
      S_EX0:     state_nxt = S_EX1;
      S_EX1:     state_nxt = S_EX2;
      S_EX2:     state_nxt = S_DN;
      S_DN: begin
        if (pos_r == '0 || !l_ok) begin
          state_nxt = S_CH;
        end else begin
          state_nxt = S_DN_L;
        end
      end
      S_DN_L:    state_nxt = r_ok ? S_DN_R : S_DN_MV;
      S_DN_R:    state_nxt = S_DN_MV;
      S_DN_MV:   state_nxt = smv_r ? S_DN : S_CH;
      S_CH:      state_nxt = c_ok ? S_CH_CMP : S_WRITE;
      S_CH_CMP:  state_nxt = left_lt ? S_DN : S_WRITE;
      S_WRITE:   state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    cnt_nxt   = cnt_r;
    v_nxt     = v_r;
    key_nxt   = key_r;
    car_nxt   = car_r;
    sm_nxt    = sm_r;
    smv_nxt   = smv_r;
    sr_nxt    = sr_r;
    pos_nxt   = pos_r;
    r_nxt     = r_r;
    base_nxt  = base_r;
    f_nxt     = f_r;
    c_nxt     = c_r;
    ov_nxt    = ov_r;
    ok_nxt    = ok_r;
    st_nxt    = st_r;
    heap_port = '0;
    pos_port  = '0;
    div_req   = '0;
    div_req.dividend = pos_r - PW'(1);
    div_req.divisor  = d;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          v_nxt   = in_vertex;
          key_nxt = in_new_key;
          ov_nxt  = in_vertex;
          ok_nxt  = '0;
          st_nxt  = ST_OK;
          if (in_cmd == CMD_EXTRACT && cnt_r == '0) begin
            ov_nxt = '0;
            st_nxt = ST_EMPTY;
          end
        end
      end
      S_LOOKUP: begin
        pos_port.raddr = v_r;
      end
      S_POS: begin
        pos_nxt         = pos_rd;
        heap_port.raddr = pos_rd;
        if (!p_in) begin
          // Absent vertex: insert at the tail
          if (full) begin
            st_nxt = ST_FULL;
          end else begin
            pos_nxt = cnt_r[PW-1:0];
            cnt_nxt = cnt_r + CW'(1);
            car_nxt = '{key: key_r, vtx: v_r};
            ok_nxt  = key_r;
          end
        end
      end
      S_CHECK: begin
        if (pres) begin
          if (key_r > heap_rd.key) begin
            ok_nxt = heap_rd.key;
            st_nxt = ST_LARGER;
          end else begin
            car_nxt = '{key: key_r, vtx: v_r};
            ok_nxt  = key_r;
          end
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          pos_nxt = cnt_r[PW-1:0];
          cnt_nxt = cnt_r + CW'(1);
          car_nxt = '{key: key_r, vtx: v_r};
          ok_nxt  = key_r;
        end
      end
      S_UP: begin
        div_req.start = (pos_r != '0);
      end
      S_DIV: begin
        if (div_rsp.done) begin
          r_nxt    = RW'(div_rsp.rem) + RW'(1);
          base_nxt = pos_r - PW'(1) - PW'(div_rsp.rem);
          f_nxt    = div_rsp.quot;
        end
      end
      S_GRP: begin
        heap_port.raddr = (r_r > RW'(1)) ? grp_q : f_r;
      end
      S_GRP_CMP: begin
        // Climb within the sibling group
        if (up_swap) begin
          heap_port.we    = 1'b1;
          heap_port.waddr = pos_r;
          heap_port.wdata = heap_rd;
          pos_port.we     = 1'b1;
          pos_port.waddr  = heap_rd.vtx;
          pos_port.wdata  = pos_r;
          pos_nxt         = grp_q;
          r_nxt           = r_r >> 1;
        end
      end
      S_PAR_RD: begin
        heap_port.raddr = f_r;
      end
      S_PAR_CMP: begin
        // Swap with the parent node
        if (up_swap) begin
          heap_port.we    = 1'b1;
          heap_port.waddr = pos_r;
          heap_port.wdata = heap_rd;
          pos_port.we     = 1'b1;
          pos_port.waddr  = heap_rd.vtx;
          pos_port.wdata  = pos_r;
          pos_nxt         = f_r;
        end
      end
      S_EX0: begin
        heap_port.raddr = '0;
      end
      S_EX1: begin
        ov_nxt          = heap_rd.vtx;
        ok_nxt          = heap_rd.key;
        heap_port.raddr = PW'(cnt_r - CW'(1));
      end
      S_EX2: begin
        car_nxt = heap_rd;
        cnt_nxt = cnt_r - CW'(1);
        pos_nxt = '0;
      end
      S_DN: begin
        heap_port.raddr = l_addr[PW-1:0];
        smv_nxt         = 1'b0;
      end
      S_DN_L: begin
        heap_port.raddr = r_addr[PW-1:0];
        if (left_lt) begin
          sm_nxt  = heap_rd;
          smv_nxt = 1'b1;
          sr_nxt  = l_idx[RW-1:0];
        end
      end
      S_DN_R: begin
        if (right_lt) begin
          sm_nxt  = heap_rd;
          smv_nxt = 1'b1;
          sr_nxt  = r_idx[RW-1:0];
        end
      end
      S_DN_MV: begin
        // Sink within the sibling group
        if (smv_r) begin
          heap_port.we    = 1'b1;
          heap_port.waddr = pos_r;
          heap_port.wdata = sm_r;
          pos_port.we     = 1'b1;
          pos_port.waddr  = sm_r.vtx;
          pos_port.wdata  = pos_r;
          pos_nxt         = base_r + PW'(sr_r);
          r_nxt           = sr_r;
        end
      end
      S_CH: begin
        c_nxt           = c_full[PW-1:0];
        heap_port.raddr = c_full[PW-1:0];
      end
      S_CH_CMP: begin
        // Swap with the first member of the child group
        if (left_lt) begin
          heap_port.we    = 1'b1;
          heap_port.waddr = pos_r;
          heap_port.wdata = heap_rd;
          pos_port.we     = 1'b1;
          pos_port.waddr  = heap_rd.vtx;
          pos_port.wdata  = pos_r;
          pos_nxt         = c_r;
          r_nxt           = RW'(1);
          base_nxt        = c_r - PW'(1);
        end
      end
      S_WRITE: begin
        // Drop the carried entry into the hole
        heap_port.we    = 1'b1;
        heap_port.waddr = pos_r;
        heap_port.wdata = car_r;
        pos_port.we     = 1'b1;
        pos_port.waddr  = car_r.vtx;
        pos_port.wdata  = pos_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= (state_r == S_DONE);
    end
    v_r    <= v_nxt;
    key_r  <= key_nxt;
    car_r  <= car_nxt;
    sm_r   <= sm_nxt;
    smv_r  <= smv_nxt;
    sr_r   <= sr_nxt;
    pos_r  <= pos_nxt;
    r_r    <= r_nxt;
    base_r <= base_nxt;
    f_r    <= f_nxt;
    c_r    <= c_nxt;
    ov_r   <= ov_nxt;
    ok_r   <= ok_nxt;
    st_r   <= st_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = oval_r;
  assign out_vertex    = ov_r;
  assign out_key       = ok_r;
  assign out_status    = st_r;
  assign out_occupancy = cnt_r;

  `DMH_ASSERT(a_strobe_idle, clk, rst_n, out_valid |-> !busy)
  `DMH_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy)
  `DMH_ASSERT(a_cnt_cap, clk, rst_n, cnt_r <= CW'(CAPACITY))
  `DMH_ASSERT(a_full_occ, clk, rst_n, (out_valid && st_r == ST_FULL) |-> full)
  `DMH_ASSERT_NR(a_rst_idle, clk, !rst_n |=> !busy)

endmodule

`default_nettype wire

>>> hdl/dary_min_heap_decrease_key_unit.sv
// ----------------------------------------------------------------------------
// dary_min_heap_decrease_key_unit
// Indexed d-ary min-priority queue with insert, decrease-key and extract-min.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         in_cmd, in_vertex, in_new_key
//  result    out_valid (strobe)   out_vertex, out_key, out_status, out_occupancy
//  config    cfg_valid/cfg_ready  cfg_arity
//
//  One command at a time; the result strobe comes in the same cycle as busy
//  falls, and the next item may be accepted in that cycle.
//  Extract from a non-empty heap reads the root and the last entry, then
//  sinks level by level in rounds of in-group compares and a last compare;
//  an empty extract or a no-op goes straight to the done state.
//  Insert and decrease look up the position (and read the entry when the
//  lookup hits the heap), then examine parent levels and in-group compares,
//  at a pace set by the one read port per memory and the position divider.
//  Reset empties the heap and sets the arity to 2; the memories are not cleared.
//  Results cannot be stalled; cfg_ready is high while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dary_min_heap_decrease_key_unit
  import dmh_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      in_cmd,
  input  wire logic [VW-1:0]   in_vertex,
  input  wire logic [KW-1:0]   in_new_key,
  output logic                 out_valid,
  output logic      [VW-1:0]   out_vertex,
  output logic      [KW-1:0]   out_key,
  output logic      [1:0]      out_status,
  output logic      [CW-1:0]   out_occupancy,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [DW-1:0]   cfg_arity
);

  logic [DW-1:0] arity_r;
  heap_port_t    heap_port;
  heap_ent_t     heap_rd;
  pos_port_t     pos_port;
  logic [PW-1:0] pos_rd;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  // Arity register
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arity_r <= DW'(ARITY_RST);
    end else if (cfg_valid && cfg_ready) begin
      arity_r <= cfg_arity;
    end
  end

  dmh_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_vertex     (in_vertex),
    .in_new_key    (in_new_key),
    .out_valid     (out_valid),
    .out_vertex    (out_vertex),
    .out_key       (out_key),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .arity         (arity_r),
    .heap_port     (heap_port),
    .heap_rd       (heap_rd),
    .pos_port      (pos_port),
    .pos_rd        (pos_rd),
    .div_req       (div_req),
    .div_rsp       (div_rsp)
  );

  // Key and vertex by heap position
  dmh_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(CAPACITY)) u_heap_ram (
    .clk   (clk),
    .we    (heap_port.we),
    .waddr (heap_port.waddr),
    .wdata (heap_port.wdata),
    .raddr (heap_port.raddr),
    .rdata (heap_rd)
  );

  // Heap position by vertex
  dmh_ram #(.WIDTH(PW), .DEPTH(NUM_VTX)) u_pos_ram (
    .clk   (clk),
    .we    (pos_port.we),
    .waddr (pos_port.waddr),
    .wdata (pos_port.wdata),
    .raddr (pos_port.raddr),
    .rdata (pos_rd)
  );

  dmh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

`default_nettype wire
